// ----- hdl/eqrc_pkg.sv -----
// Shared types, codes and the relation update rule of the equality closure block.
package eqrc_pkg;

  localparam int MAX_VARS_DEF = 32;

  localparam int VAR_W = 5;
  localparam int CNT_W = 6;

  localparam logic [1:0] REL_UNKNOWN = 2'd0;
  localparam logic [1:0] REL_EQ      = 2'd1;
  localparam logic [1:0] REL_NEQ     = 2'd2;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNSAT = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD_EQ  = 2'd0,
    OP_ADD_NEQ = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            op;
    logic [VAR_W-1:0]   lo;
    logic [VAR_W-1:0]   hi;
    logic [CNT_W-1:0]   n;
    logic               err;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] relation;
    logic       index_error;
  } rsp_t;

  typedef struct packed {
    logic       conflict;
    logic [1:0] value;
  } rel_upd_t;

  // Propagate relation src onto entry dst under an add-equal or add-not-equal walk.
  function automatic rel_upd_t rel_apply(logic mode_eq, logic [1:0] src, logic [1:0] dst);
    rel_upd_t r;
    r.conflict = 1'b0;
    r.value    = dst;
    if (mode_eq) begin
      if (src == REL_EQ) begin
        r.conflict = (dst == REL_NEQ);
        r.value    = REL_EQ;
      end else if (src == REL_NEQ) begin
        r.conflict = (dst == REL_EQ);
        r.value    = REL_NEQ;
      end
    end else if (src == REL_EQ) begin
      r.conflict = (dst == REL_EQ);
      r.value    = REL_NEQ;
    end
    return r;
  endfunction

endpackage

// ----- hdl/eqrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module eqrc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/eqrc_seq.sv -----
// Walk sequencer: clearing pass, pair lookup and column closure over the relation RAM.
module eqrc_seq #(
  parameter int MAX_VARS = eqrc_pkg::MAX_VARS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  eqrc_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output eqrc_pkg::rsp_t rsp
);
  import eqrc_pkg::*;

  localparam int IW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_PRD  = 10'b00_0000_0100,
    S_PCHK = 10'b00_0000_1000,
    S_COL  = 10'b00_0001_0000,
    S_RDL  = 10'b00_0010_0000,
    S_RDX  = 10'b00_0100_0000,
    S_UPD  = 10'b00_1000_0000,
    S_WRL  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t           state, state_next;
  opcode_t          op;
  logic [VAR_W-1:0] lo, hi;
  logic [CNT_W-1:0] n, j;
  logic             phase;
  logic [1:0]       lval, lnew;
  logic [1:0]       rel;
  logic             err;
  logic [1:0]       status;
  logic [AW-1:0]    clr_addr;
  logic             clr_reply;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [1:0]       wdata, rdata;
  logic             mode_eq;
  rel_upd_t         pair_upd, x_upd, l_upd;

  function automatic logic [AW-1:0] maddr(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
    return {IW'(r), IW'(c)};
  endfunction

  eqrc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mode_eq  = (op == OP_ADD_EQ);
  assign pair_upd = rel_apply(mode_eq, REL_EQ, rdata);
  assign x_upd    = rel_apply(mode_eq, lval, rdata);
  assign l_upd    = rel_apply(mode_eq, x_upd.value, lval);

  assign cmd_ready       = (state == S_IDLE);
  assign rsp_valid       = (state == S_FIN);
  assign rsp.status      = status;
  assign rsp.relation    = rel;
  assign rsp.index_error = err;

  always_comb begin
    raddr = maddr(CNT_W'(lo), CNT_W'(hi));
    unique case (state)
      S_RDL:   raddr = maddr(CNT_W'(lo), j);
      S_RDX:   raddr = phase ? maddr(CNT_W'(hi), j) : maddr(j, CNT_W'(hi));
      default: raddr = maddr(CNT_W'(lo), CNT_W'(hi));
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = REL_UNKNOWN;
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = (clr_addr[AW-1:IW] == clr_addr[IW-1:0]) ? REL_EQ : REL_UNKNOWN;
      end
      S_PCHK: begin
        we    = (op != OP_QUERY) && !pair_upd.conflict;
        waddr = maddr(CNT_W'(lo), CNT_W'(hi));
        wdata = pair_upd.value;
      end
      S_UPD: begin
        we    = !x_upd.conflict;
        waddr = phase ? maddr(CNT_W'(hi), j) : maddr(j, CNT_W'(hi));
        wdata = x_upd.value;
      end
      S_WRL: begin
        we    = 1'b1;
        waddr = maddr(CNT_W'(lo), j);
        wdata = lnew;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (&clr_addr) begin
          state_next = clr_reply ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_CLEAR) begin
            state_next = S_CLR;
          end else if (cmd.err || status == ST_UNSAT) begin
            state_next = S_FIN;
          end else if (cmd.op != OP_QUERY && cmd.lo == cmd.hi) begin
            state_next = S_FIN;
          end else begin
            state_next = S_PRD;
          end
        end
      end
      S_PRD:  state_next = S_PCHK;
      S_PCHK: begin
        if (op == OP_QUERY || pair_upd.conflict) begin
          state_next = S_FIN;
        end else begin
          state_next = S_COL;
        end
      end
      S_COL: begin
        if (!phase) begin
          if (j < {1'b0, hi}) begin
            state_next = S_RDL;
          end
        end else if (j < n) begin
          state_next = S_RDL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RDL: state_next = S_RDX;
      S_RDX: state_next = S_UPD;
      S_UPD: begin
        if (x_upd.conflict || (phase && l_upd.conflict)) begin
          state_next = S_FIN;
        end else if (phase) begin
          state_next = S_WRL;
        end else begin
          state_next = S_COL;
        end
      end
      S_WRL: state_next = S_COL;
      S_FIN: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      status    <= ST_NONE;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_CLEAR) begin
              status    <= ST_NONE;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
            end else if (!cmd.err && status != ST_UNSAT && cmd.lo == cmd.hi) begin
              if (cmd.op == OP_ADD_EQ) begin
                status <= ST_SAT;
              end else if (cmd.op == OP_ADD_NEQ) begin
                status <= ST_UNSAT;
              end
            end
          end
        end
        S_PCHK: begin
          if (op != OP_QUERY && pair_upd.conflict) begin
            status <= ST_UNSAT;
          end
        end
        S_COL: begin
          if (phase && !(j < n)) begin
            status <= ST_SAT;
          end
        end
        S_UPD: begin
          if (x_upd.conflict || (phase && l_upd.conflict)) begin
            status <= ST_UNSAT;
          end
        end
        default: status <= status;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          op  <= cmd.op;
          lo  <= cmd.lo;
          hi  <= cmd.hi;
          n   <= cmd.n;
          err <= (cmd.op == OP_CLEAR) ? 1'b0 : cmd.err;
          rel <= REL_UNKNOWN;
        end
      end
      S_PCHK: begin
        if (op == OP_QUERY) begin
          rel <= rdata;
        end
        j     <= CNT_W'(lo) + CNT_W'(1);
        phase <= 1'b0;
      end
      S_COL: begin
        if (!phase && !(j < {1'b0, hi})) begin
          phase <= 1'b1;
          j     <= CNT_W'(hi) + CNT_W'(1);
        end
      end
      S_RDX: lval <= rdata;
      S_UPD: begin
        lnew <= l_upd.value;
        if (!phase) begin
          j <= j + CNT_W'(1);
        end
      end
      S_WRL: j <= j + CNT_W'(1);
      default: lval <= lval;
    endcase
  end

endmodule

// ----- hdl/equality_relation_closure.sv -----
// Equality closure top level: stream ports, var_count register and result register.
// A query reads the pair entry; an add reads the pair, then walks each column between the pair
// and each column past the high index, paced by the one-read-port relation RAM.
// Clear writes all 2^(2*ceil(log2 MAX_VARS)) RAM entries (1024 at the default), one entry a cycle.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset runs the same clearing pass before the first item; var_count resets to 32.
module equality_relation_closure #(
  parameter int MAX_VARS = eqrc_pkg::MAX_VARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,       // var_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // opcode[1:0], var_a[6:2], var_b[11:7], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // status[1:0], relation[3:2], index_error[4], zero pad
);
  import eqrc_pkg::*;

  logic [CNT_W-1:0] var_count;
  logic [CNT_W-1:0] eff_n;
  logic [VAR_W-1:0] var_a, var_b;
  cmd_t             cmd;
  rsp_t             rsp;
  logic             rsp_valid, rsp_ready;
  logic [7:0]       out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count <= CNT_W'(32);
    end else if (cfg_valid) begin
      var_count <= cfg_data;
    end
  end

  assign eff_n = (int'(var_count) > MAX_VARS) ? CNT_W'(MAX_VARS) : var_count;
  assign var_a = s_axis_tdata[6:2];
  assign var_b = s_axis_tdata[11:7];

  assign cmd.op  = opcode_t'(s_axis_tdata[1:0]);
  assign cmd.lo  = (var_a <= var_b) ? var_a : var_b;
  assign cmd.hi  = (var_a <= var_b) ? var_b : var_a;
  assign cmd.n   = eff_n;
  assign cmd.err = ({1'b0, var_a} >= eff_n) || ({1'b0, var_b} >= eff_n);

  eqrc_seq #(.MAX_VARS(MAX_VARS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_axis_tvalid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data <= {3'b000, rsp.index_error, rsp.relation, rsp.status};
    end
  end

  assign m_axis_tdata = out_data;

endmodule
